>>> hdl/dtre_pkg.sv
package dtre_pkg;

  // window geometry
  localparam int unsigned WINDOW_DEPTH = 32;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // field widths
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned RATE_W  = 30;
  localparam int unsigned STEP_W  = 24;

  // running sums and slope arithmetic
  localparam int unsigned SUM_W  = DELAY_W + CNT_W;
  localparam int unsigned WSUM_W = DELAY_W + 2 * CNT_W;
  localparam int unsigned SX_W   = 2 * CNT_W;
  localparam int unsigned DEN_W  = 4 * CNT_W;
  localparam int unsigned NUM_W  = WSUM_W + CNT_W + 6;

  // shared multiplier
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // divide by 100: reciprocal multiply plus one correction step
  localparam int unsigned Q_W          = RATE_W - 6;
  localparam int unsigned REM_W        = 7;
  localparam int unsigned RP_W         = 14;
  localparam int unsigned DEC_W        = RATE_W + 2;
  localparam int unsigned RECIP_SHIFT  = RATE_W + PCT_W;
  localparam int unsigned RECIP2_SHIFT = 21;
  localparam logic [MUL_W-1:0] RECIP_M  = MUL_W'((64'd1 << RECIP_SHIFT) / 64'd100);
  localparam logic [MUL_W-1:0] RECIP2_M = MUL_W'((64'd1 << RECIP2_SHIFT) / 64'd100);

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // apb
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // stream payloads
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  // register reset values
  localparam logic [THR_W-1:0]  OVER_THR_RST   = 8'h08;
  localparam logic [THR_W-1:0]  UNDER_THR_RST  = 8'hF8;
  localparam logic [PCT_W-1:0]  DEC_PCT_RST    = 7'd85;
  localparam logic [RATE_W-1:0] MIN_RATE_RST   = 30'd50000;
  localparam logic [STEP_W-1:0] INC_STEP_RST   = 24'd100000;
  localparam logic [RATE_W-1:0] MAX_RATE_RST   = 30'd1000000000;
  localparam logic [RATE_W-1:0] START_RATE_RST = 30'd300000;

  typedef enum logic [2:0] {
    REG_OVER_THR   = 3'd0,
    REG_UNDER_THR  = 3'd1,
    REG_DEC_PCT    = 3'd2,
    REG_MIN_RATE   = 3'd3,
    REG_INC_STEP   = 3'd4,
    REG_MAX_RATE   = 3'd5,
    REG_START_RATE = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    USE_NORMAL = 2'd0,
    USE_OVER   = 2'd1,
    USE_UNDER  = 2'd2
  } usage_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_NW,
    ST_SXS,
    ST_THR_O,
    ST_THR_U,
    ST_QEST,
    ST_QLOAD,
    ST_QFIX,
    ST_QP,
    ST_RP,
    ST_RPM,
    ST_TFIX,
    ST_FIN,
    ST_DONE
  } seq_e;

  typedef struct packed {
    logic signed [THR_W-1:0] over_thr;
    logic signed [THR_W-1:0] under_thr;
    logic [PCT_W-1:0]        dec_pct;
    logic [RATE_W-1:0]       min_rate;
    logic [STEP_W-1:0]       inc_step;
    logic [RATE_W-1:0]       max_rate;
    logic [RATE_W-1:0]       start_rate;
  } cfg_t;

  typedef struct packed {
    logic       slope_valid;
    usage_e     usage;
    logic [RATE_W-1:0] rate;
  } res_t;

  // sum of indices n(n-1)/2 and slope denominator n^2(n^2-1)/12, per fill count
  typedef logic [WINDOW_DEPTH:0][SX_W-1:0]  sx_tab_t;
  typedef logic [WINDOW_DEPTH:0][DEN_W-1:0] den_tab_t;

  function automatic sx_tab_t sx_table();
    sx_tab_t tab;
    longint  n;
    for (int i = 0; i <= WINDOW_DEPTH; i++) begin
      n      = longint'(i);
      tab[i] = SX_W'(n * (n - 1) / 2);
    end
    return tab;
  endfunction

  function automatic den_tab_t den_table();
    den_tab_t tab;
    longint   n;
    for (int i = 0; i <= WINDOW_DEPTH; i++) begin
      n      = longint'(i);
      tab[i] = DEN_W'(n * n * (n * n - 1) / 12);
    end
    return tab;
  endfunction

  localparam sx_tab_t  SX_TAB  = sx_table();
  localparam den_tab_t DEN_TAB = den_table();

endpackage

>>> hdl/dtre_window_ram.sv
module dtre_window_ram
  import dtre_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [SLOT_W-1:0]  waddr_i,
  input  logic [DELAY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [SLOT_W-1:0]  raddr_i,
  output logic [DELAY_W-1:0] rdata_o
);

  logic [DELAY_W-1:0] mem [WINDOW_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hdl/dtre_mul.sv
module dtre_mul
  import dtre_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  // product registered, ready in the cycle after the operands
  always_ff @(posedge clk_i) begin
    prod_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

>>> hdl/dtre_core.sv
module dtre_core
  import dtre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              rate_load_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       send_i,
  input  logic [31:0]       recv_i,
  output res_t              res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);

  seq_e state_q, state_d;

  logic signed [DELAY_W-1:0] d_q;
  logic [CNT_W-1:0]          fill_q;
  logic [SLOT_W-1:0]         oldest_q;
  logic signed [SUM_W-1:0]   s_q;
  logic signed [WSUM_W-1:0]  w_q;
  usage_e                    det_q;
  logic [RATE_W-1:0]         rate_q;

  logic signed [NUM_W-1:0]   nw_q;
  logic signed [NUM_W-1:0]   num16_q;
  logic                      over_q, under_q;
  logic [Q_W-1:0]            q_q;
  logic [REM_W-1:0]          r_q;
  logic [Q_W+PCT_W-1:0]      qp_q;
  logic [RP_W-1:0]           rp_q;
  logic [PCT_W-1:0]          t_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      ram_re, ram_we;
  logic [DELAY_W-1:0]        ram_rdata;
  logic [SLOT_W-1:0]         slot;

  // delay of the incoming packet, saturated to 16 bit
  logic signed [32:0]        diff;
  logic signed [DELAY_W-1:0] d_sat;

  always_comb begin
    diff = $signed({1'b0, recv_i}) - $signed({1'b0, send_i});
    if (diff > 33'sd32767) begin
      d_sat = 16'sh7FFF;
    end else if (diff < -33'sd32768) begin
      d_sat = 16'sh8000;
    end else begin
      d_sat = diff[DELAY_W-1:0];
    end
  end

  // window update
  logic                          full;
  logic signed [DELAY_W-1:0]     y0;
  logic [CNT_W-1:0]              factor;
  logic signed [DELAY_W+CNT_W:0] fd;
  logic signed [SUM_W-1:0]       drop;
  logic [CNT_W:0]                slot_sum;

  always_comb begin
    full     = (fill_q == CNT_W'(WINDOW_DEPTH));
    y0       = full ? $signed(ram_rdata) : '0;
    factor   = full ? CNT_W'(WINDOW_DEPTH - 1) : fill_q;
    fd       = $signed({1'b0, factor}) * d_q;
    drop     = full ? (s_q - SUM_W'(y0)) : '0;
    slot_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(fill_q);
    if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      slot_sum = slot_sum - (CNT_W + 1)'(WINDOW_DEPTH);
    end
    slot = full ? oldest_q : slot_sum[SLOT_W-1:0];
  end

  // divide-by-100 corrections
  logic [RATE_W-1:0]  q100, r_full;
  logic [7:0]         r8;
  logic [PCT_W-1:0]   t_est;
  logic [RP_W-1:0]    t100, t_rem;

  always_comb begin
    q100   = (RATE_W'(q_q) << 6) + (RATE_W'(q_q) << 5) + (RATE_W'(q_q) << 2);
    r_full = rate_q - q100;
    r8     = r_full[7:0];
    t_est  = prod[RECIP2_SHIFT +: PCT_W];
    t100   = (RP_W'(t_est) << 6) + (RP_W'(t_est) << 5) + (RP_W'(t_est) << 2);
    t_rem  = rp_q - t100;
  end

  // rate candidates
  logic [DEC_W-1:0]  dec_full;
  logic [RATE_W-1:0] dec_sat, dec_rate;
  logic [RATE_W:0]   inc_full;
  logic [RATE_W-1:0] inc_rate;
  logic              slope_ok;
  usage_e            det_new;

  always_comb begin
    dec_full = DEC_W'(qp_q) + DEC_W'(t_q);
    dec_sat  = (dec_full > DEC_W'(RATE_MAX)) ? RATE_MAX : dec_full[RATE_W-1:0];
    dec_rate = (dec_sat < cfg_i.min_rate) ? cfg_i.min_rate : dec_sat;
    inc_full = (RATE_W + 1)'(rate_q) + (RATE_W + 1)'(cfg_i.inc_step);
    inc_rate = (inc_full > (RATE_W + 1)'(cfg_i.max_rate)) ? cfg_i.max_rate
                                                          : inc_full[RATE_W-1:0];
    slope_ok = (fill_q >= CNT_W'(4));
    if (over_q) begin
      det_new = USE_OVER;
    end else if (under_q) begin
      det_new = USE_UNDER;
    end else begin
      det_new = USE_NORMAL;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_UPD;
      ST_UPD:   state_d = ST_NW;
      ST_NW:    state_d = ST_SXS;
      ST_SXS:   state_d = ST_THR_O;
      ST_THR_O: state_d = ST_THR_U;
      ST_THR_U: state_d = ST_QEST;
      ST_QEST:  state_d = ST_QLOAD;
      ST_QLOAD: state_d = ST_QFIX;
      ST_QFIX:  state_d = ST_QP;
      ST_QP:    state_d = ST_RP;
      ST_RP:    state_d = ST_RPM;
      ST_RPM:   state_d = ST_TFIX;
      ST_TFIX:  state_d = ST_FIN;
      ST_FIN:   state_d = ST_DONE;
      ST_DONE:  if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      ST_UPD: ram_we = 1'b1;
      ST_NW: begin
        mul_a = MUL_W'(fill_q);
        mul_b = MUL_W'(w_q);
      end
      ST_SXS: begin
        mul_a = MUL_W'(SX_TAB[fill_q]);
        mul_b = MUL_W'(s_q);
      end
      ST_THR_O: begin
        mul_a = MUL_W'($signed(cfg_i.over_thr));
        mul_b = MUL_W'(DEN_TAB[fill_q]);
      end
      ST_THR_U: begin
        mul_a = MUL_W'($signed(cfg_i.under_thr));
        mul_b = MUL_W'(DEN_TAB[fill_q]);
      end
      ST_QEST: begin
        mul_a = MUL_W'(rate_q);
        mul_b = RECIP_M;
      end
      ST_QP: begin
        mul_a = MUL_W'(q_q);
        mul_b = MUL_W'(cfg_i.dec_pct);
      end
      ST_RP: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(cfg_i.dec_pct);
      end
      ST_RPM: begin
        mul_a = MUL_W'(prod[RP_W-1:0]);
        mul_b = RECIP2_M;
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_o.rate        = rate_q;
    res_o.usage       = det_q;
    res_o.slope_valid = slope_ok;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      s_q      <= '0;
      w_q      <= '0;
      det_q    <= USE_NORMAL;
      rate_q   <= START_RATE_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_UPD) begin
        s_q <= s_q - SUM_W'(y0) + SUM_W'(d_q);
        w_q <= w_q - WSUM_W'(drop) + WSUM_W'(fd);
        if (full) begin
          oldest_q <= (oldest_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
        end else begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (rate_load_i) begin
        rate_q <= cfg_i.start_rate;
      end else if (state_q == ST_FIN && slope_ok) begin
        det_q <= det_new;
        if (det_new == USE_OVER) begin
          if (det_q != USE_OVER) rate_q <= dec_rate;
        end else begin
          rate_q <= inc_rate;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) d_q <= d_sat;
      ST_SXS:   nw_q <= NUM_W'(prod);
      ST_THR_O: num16_q <= (nw_q - NUM_W'(prod)) <<< 4;
      ST_THR_U: over_q <= (PROD_W'(num16_q) > prod);
      ST_QEST:  under_q <= (PROD_W'(num16_q) < prod);
      ST_QLOAD: q_q <= prod[RECIP_SHIFT +: Q_W];
      ST_QFIX: begin
        if (r8 >= 8'd100) begin
          q_q <= q_q + 1'b1;
          r_q <= REM_W'(r8 - 8'd100);
        end else begin
          r_q <= r8[REM_W-1:0];
        end
      end
      ST_RP:    qp_q <= prod[Q_W+PCT_W-1:0];
      ST_RPM:   rp_q <= prod[RP_W-1:0];
      ST_TFIX:  t_q <= (t_rem >= RP_W'(100)) ? t_est + 1'b1 : t_est;
      default: ;
    endcase
  end

  dtre_window_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (d_q),
    .re_i    (ram_re),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  dtre_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

endmodule

>>> hdl/delay_trend_rate_estimator.sv
// channel | dir | beat contents (lowest bit up)
// --------+-----+-----------------------------------------------------------
// s_axis  | in  | tdata: send_stamp[31:0], recv_stamp[63:32]
// m_axis  | out | tdata: rate_bps[29:0], usage_state[31:30], slope_valid[32],
//         |     |        zero[39:33]
// apb     | cfg | seven registers at byte address 4*index, write and read
//
// the shared 32x32 multiplier is stepped through eight slots (slope terms,
// thresholds, the divide by 100 of the decrease), and the next packet is
// taken only after the core has handed its result to the output register.
// the delay window sits in a 32 entry ram that is read at accept and
// written in the cycle after, so no forwarding is needed. reset clears the
// sums, fill count, detector state and loads the start rate; the ram needs
// no clearing pass. a stalled result waits in the output register while the
// next packet is already being worked on.
module delay_trend_rate_estimator
  import dtre_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // packet timestamps: send_stamp[31:0], recv_stamp[63:32]
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,

  // estimate: rate_bps[29:0], usage_state[31:30], slope_valid[32], zero[39:33]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // configuration registers
  logic [THR_W-1:0]  over_thr_q, under_thr_q;
  logic [PCT_W-1:0]  dec_pct_q;
  logic [RATE_W-1:0] min_rate_q, max_rate_q, start_rate_q;
  logic [STEP_W-1:0] inc_step_q;

  logic  apb_wr;
  reg_e  reg_idx;
  logic  rate_load;
  cfg_t  cfg;

  assign pready    = 1'b1;
  assign apb_wr    = psel && penable && pwrite;
  assign reg_idx   = reg_e'(paddr[APB_AW-1:2]);
  assign rate_load = apb_wr && (reg_idx == REG_START_RATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_thr_q   <= OVER_THR_RST;
      under_thr_q  <= UNDER_THR_RST;
      dec_pct_q    <= DEC_PCT_RST;
      min_rate_q   <= MIN_RATE_RST;
      inc_step_q   <= INC_STEP_RST;
      max_rate_q   <= MAX_RATE_RST;
      start_rate_q <= START_RATE_RST;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_OVER_THR:   over_thr_q   <= pwdata[THR_W-1:0];
        REG_UNDER_THR:  under_thr_q  <= pwdata[THR_W-1:0];
        REG_DEC_PCT:    dec_pct_q    <= pwdata[PCT_W-1:0];
        REG_MIN_RATE:   min_rate_q   <= pwdata[RATE_W-1:0];
        REG_INC_STEP:   inc_step_q   <= pwdata[STEP_W-1:0];
        REG_MAX_RATE:   max_rate_q   <= pwdata[RATE_W-1:0];
        REG_START_RATE: start_rate_q <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback, unused addresses read as zero
  always_comb begin
    unique case (reg_idx)
      REG_OVER_THR:   prdata = APB_DW'(over_thr_q);
      REG_UNDER_THR:  prdata = APB_DW'(under_thr_q);
      REG_DEC_PCT:    prdata = APB_DW'(dec_pct_q);
      REG_MIN_RATE:   prdata = APB_DW'(min_rate_q);
      REG_INC_STEP:   prdata = APB_DW'(inc_step_q);
      REG_MAX_RATE:   prdata = APB_DW'(max_rate_q);
      REG_START_RATE: prdata = APB_DW'(start_rate_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.over_thr   = over_thr_q;
    cfg.under_thr  = under_thr_q;
    cfg.dec_pct    = dec_pct_q;
    cfg.min_rate   = min_rate_q;
    cfg.inc_step   = inc_step_q;
    cfg.max_rate   = max_rate_q;
    // a start rate write loads the estimate with the value being written
    cfg.start_rate = rate_load ? pwdata[RATE_W-1:0] : start_rate_q;
  end

  // sequencer, window ram and multiplier
  res_t res;
  logic res_valid, res_ready;

  dtre_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .rate_load_i (rate_load),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .send_i      (s_axis_tdata_i[31:0]),
    .recv_i      (s_axis_tdata_i[63:32]),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  // output register, frees the core while a result beat is stalled
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= OUT_TDATA_W'(res);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // one packet in flight: after a packet is taken the input closes
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a packet is in flight");

  // a result handed over by the core shows up on the output
  a_res_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_valid_q)
    else $error("core result lost at output register");

  // detector code is never the unused value
  a_usage_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31:30] != 2'b11))
    else $error("illegal usage state on output");
`endif

endmodule
